>>> rtl/core/base64_stream_encoder_defines.svh
// Assertion macros for the base64 stream encoder.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define B64E_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define B64E_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define B64E_ASSERT_IMP(lbl, ante, cons)
`define B64E_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/b64e_pkg.sv
package b64e_pkg;

  // ASCII codes used by the character map.
  localparam logic [6:0] CHR_UPPER_A = 7'h41;
  localparam logic [6:0] CHR_LOWER_A = 7'h61;
  localparam logic [6:0] CHR_DIGIT_0 = 7'h30;
  localparam logic [6:0] CHR_PLUS    = 7'h2B;
  localparam logic [6:0] CHR_SLASH   = 7'h2F;
  localparam logic [6:0] CHR_PAD     = 7'h3D;

  // Characters carried by one queued job.
  localparam int JOB_CHARS = 4;
  localparam int IDX_W     = $clog2(JOB_CHARS);

  // Job queue depth between the front and back parts.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Input word: one raw byte and its end-of-message mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  // Output word: one ASCII character and its end-of-message mark.
  typedef struct packed {
    logic [6:0] out_char;
    logic       end_of_text;
  } out_word_t;

  // Position inside a three-byte group.
  typedef enum logic [2:0] {
    PH0 = 3'b001,
    PH1 = 3'b010,
    PH2 = 3'b100
  } phase_t;

  // One classified byte: the characters it produces, ready to send.
  typedef struct packed {
    logic [JOB_CHARS-1:0][6:0] chars;
    logic [IDX_W-1:0]          last_idx;
    logic                      fin;
  } job_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // Map a 6-bit value to its base64 ASCII character.
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = CHR_UPPER_A + {1'b0, v};
      [6'd26:6'd51]: c = CHR_LOWER_A + {1'b0, v} - 7'd26;
      [6'd52:6'd61]: c = CHR_DIGIT_0 + {1'b0, v} - 7'd52;
      6'd62:         c = CHR_PLUS;
      default:       c = CHR_SLASH;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/b64e_front.sv
module b64e_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  b64e_pkg::in_word_t in_word,
  input  b64e_pkg::q_stat_t  q_stat,
  output logic               push,
  output b64e_pkg::job_t     push_job
);
  import b64e_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] leftover, leftover_next;
  logic [7:0] b;
  logic       fin;

  assign b        = in_word.data_byte;
  assign fin      = in_word.final_byte;
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // Split the byte into characters according to the group position.
  always_comb begin
    push_job          = '0;
    push_job.fin      = fin;
    push_job.chars[2] = CHR_PAD;
    push_job.chars[3] = CHR_PAD;
    case (phase)
      PH1: begin
        push_job.chars[0] = b64_char({leftover[1:0], b[7:4]});
        leftover_next     = b[3:0];
        phase_next        = PH2;
        if (fin) begin
          push_job.chars[1] = b64_char({b[3:0], 2'b00});
          push_job.last_idx = IDX_W'(2);
        end
      end
      PH2: begin
        push_job.chars[0] = b64_char({leftover, b[7:6]});
        push_job.chars[1] = b64_char(b[5:0]);
        push_job.last_idx = IDX_W'(1);
        leftover_next     = 4'd0;
        phase_next        = PH0;
      end
      default: begin
        push_job.chars[0] = b64_char(b[7:2]);
        leftover_next     = {2'b00, b[1:0]};
        phase_next        = PH1;
        if (fin) begin
          push_job.chars[1] = b64_char({b[1:0], 4'b0000});
          push_job.last_idx = IDX_W'(3);
        end
      end
    endcase
    // The last byte closes the group and returns to the start.
    if (fin) begin
      leftover_next = 4'd0;
      phase_next    = PH0;
    end
  end

  // Group position and carried bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH0;
      leftover <= 4'd0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

>>> rtl/core/b64e_queue.sv
module b64e_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64e_pkg::job_t    push_job,
  input  logic              pop,
  output b64e_pkg::job_t    head_job,
  output b64e_pkg::q_stat_t q_stat
);
  import b64e_pkg::*;

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head_job     = entries[rd_ptr];
  assign q_stat.full  = (count == QCNT_W'(QDEPTH));
  assign q_stat.valid = (count != '0);

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/b64e_back.sv
module b64e_back (
  input  logic                clk,
  input  logic                rst,
  input  b64e_pkg::job_t      head_job,
  input  b64e_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::out_word_t out_word
);
  import b64e_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             at_last;

  assign load    = q_stat.valid && (!out_valid || out_ready);
  assign at_last = (idx == head_job.last_idx);
  assign pop     = load && at_last;

  // Walk the head job one character per cycle while the output is not stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      idx       <= at_last ? '0 : idx + 1'b1;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_word.out_char    <= head_job.chars[idx];
      out_word.end_of_text <= head_job.fin && at_last;
    end
  end

endmodule

>>> rtl/core/base64_stream_encoder.sv
// Channel | Direction | Word type   | Contents
// in      | sink      | in_word_t   | data_byte, final_byte
// out     | source    | out_word_t  | out_char, end_of_text
//
// A byte is taken whenever the two-entry job queue has room.
// Characters leave at one per cycle from the output register, set by the
// single output port, while out is not stalled; a byte yields one to four characters, about 1.33 on average.
// Reset clears the group position, the queue and the output valid flag.
// A stall on out backs up the queue; in keeps taking bytes until it is full.
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64e_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::out_word_t out_word
);
  import b64e_pkg::*;

  q_stat_t q_stat;
  job_t    push_job;
  job_t    head_job;
  logic    push;
  logic    pop;

  // Front part: classify each byte into a job of characters.
  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // Job queue between the two parts.
  b64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // Back part: send the characters of each job.
  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // The back part never retires a job from an empty queue.
  `B64E_ASSERT_IMP(a_pop_nonempty, pop, q_stat.valid)
  // A job pushed without a pop leaves the queue occupied.
  `B64E_ASSERT_NXT(a_push_holds, push && !pop, q_stat.valid)
  // A waiting job with a free output register shows a word next cycle.
  `B64E_ASSERT_NXT(a_out_loads, q_stat.valid && (!out_valid || out_ready), out_valid)

endmodule

>>> bench/tb_base64_stream_encoder.sv
`timescale 1ns / 100ps

module tb_base64_stream_encoder;
  import b64e_pkg::*;

  localparam int NUM_DIRECTED = 23;
  localparam int NUM_RANDOM   = 450;

  // Standard base64 table, entry 0 is 'A'.
  localparam logic [0:63][7:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One directed row. A nonzero text holds the characters expected for this byte,
  // right-aligned; a zero text leaves the expectation to the encoder model.
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic [31:0] txt;
  } stim_row_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // Text expected for the word currently offered, zero when predicted.
  logic [31:0] in_txt = '0;
  logic        calm_stretch = 1'b0;
  int          mismatch_count = 0;

  // Encoder model state and the characters of the latest byte.
  phase_t      grp_pos = PH0;
  logic [3:0]  carry_bits = '0;
  logic [6:0]  enc_chars [4];
  int          enc_count;
  out_word_t   chars_due [$];

  stim_row_t   directed_rows [NUM_DIRECTED];

  base64_stream_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Encode one byte: emit every complete 6-bit character, then on the final byte
  // flush the leftover bits and pad the group out to four characters.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    enc_count = 0;
    case (grp_pos)
      PH1: begin
        enc_chars[0] = B64_ALPHABET[{carry_bits[1:0], b[7:4]}][6:0];
        enc_count = 1;
        carry_bits = b[3:0];
        grp_pos = PH2;
      end
      PH2: begin
        enc_chars[0] = B64_ALPHABET[{carry_bits, b[7:6]}][6:0];
        enc_chars[1] = B64_ALPHABET[b[5:0]][6:0];
        enc_count = 2;
        carry_bits = '0;
        grp_pos = PH0;
      end
      default: begin
        enc_chars[0] = B64_ALPHABET[b[7:2]][6:0];
        enc_count = 1;
        carry_bits = {2'b00, b[1:0]};
        grp_pos = PH1;
      end
    endcase
    if (fin) begin
      if (grp_pos == PH1) begin
        enc_chars[1] = B64_ALPHABET[{carry_bits[1:0], 4'b0000}][6:0];
        enc_chars[2] = CHR_PAD;
        enc_chars[3] = CHR_PAD;
        enc_count = 4;
      end else if (grp_pos == PH2) begin
        enc_chars[1] = B64_ALPHABET[{carry_bits, 2'b00}][6:0];
        enc_chars[2] = CHR_PAD;
        enc_count = 3;
      end
      carry_bits = '0;
      grp_pos = PH0;
    end
  endfunction

  // Offer one word, after an optional idle gap, and hold it until it is taken.
  task automatic send_word(input logic [7:0] b, input logic fin, input logic [31:0] txt);
    if (!calm_stretch && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{data_byte: b, final_byte: fin};
    in_txt   <= txt;
    do @(posedge clk); while (!in_ready);
  endtask

  // Output side backpressure.
  always @(posedge clk) begin
    out_ready <= calm_stretch ? 1'b1 : ($urandom_range(0, 99) >= 33);
  end

  // Track accepted input words and check every accepted output word.
  always @(posedge clk) begin : check_words
    out_word_t want;
    int k;
    if (!rst) begin
      if (in_valid && in_ready) begin
        encode_byte(in_word.data_byte, in_word.final_byte);
        if (in_txt == '0) begin
          for (k = 0; k < enc_count; k++)
            chars_due.push_back('{out_char: enc_chars[k],
                                  end_of_text: in_word.final_byte && k == enc_count - 1});
        end else begin
          for (k = 3; k >= 0; k--)
            if (in_txt[8*k +: 8] != 8'h00)
              chars_due.push_back('{out_char: in_txt[8*k +: 7],
                                    end_of_text: in_word.final_byte && k == 0});
        end
      end
      if (out_valid && out_ready) begin
        if (chars_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, expected none, actual char %h eot %b",
                   $time, out_word.out_char, out_word.end_of_text);
        end else begin
          want = chars_due.pop_front();
          if (out_word.out_char !== want.out_char) begin
            mismatch_count++;
            $display("%0t: out_char mismatch, expected %h, actual %h",
                     $time, want.out_char, out_word.out_char);
          end
          if (out_word.end_of_text !== want.end_of_text) begin
            mismatch_count++;
            $display("%0t: end_of_text mismatch, expected %b, actual %b",
                     $time, want.end_of_text, out_word.end_of_text);
          end
        end
      end
    end
  end

  // Stimulus: directed messages first, then random messages.
  initial begin : drive_words
    int k;
    int msg_left;
    int pick;
    logic [7:0] b;
    directed_rows = '{
      // Extremes as one-byte messages.
      '{8'h00, 1'b1, "AA=="},
      '{8'hFF, 1'b1, "/w=="},
      // Full group ending the message, then a two-byte message.
      '{8'h4D, 1'b0, "T"}, '{8'h61, 1'b0, "W"}, '{8'h6E, 1'b1, "Fu"},
      '{8'h4D, 1'b0, "T"}, '{8'h61, 1'b1, "WE="},
      // All ones and all zeros across a group.
      '{8'hFF, 1'b0, "/"}, '{8'hFF, 1'b0, "/"}, '{8'hFF, 1'b1, "//"},
      '{8'h00, 1'b0, "A"}, '{8'h00, 1'b0, "A"}, '{8'h00, 1'b0, "AA"},
      // Message continues: mixed group, then a final byte in the second position.
      '{8'hFB, 1'b0, 32'h0}, '{8'hEF, 1'b0, 32'h0}, '{8'hBE, 1'b0, 32'h0},
      '{8'h01, 1'b0, 32'h0}, '{8'h80, 1'b1, 32'h0},
      // A full group followed by two bytes, the second one final.
      '{8'h7F, 1'b0, 32'h0}, '{8'h55, 1'b0, 32'h0}, '{8'hAA, 1'b0, 32'h0},
      '{8'hC3, 1'b0, 32'h0}, '{8'h3C, 1'b1, 32'h0}
    };
    msg_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < NUM_DIRECTED; k++)
      send_word(directed_rows[k].data, directed_rows[k].fin, directed_rows[k].txt);

    // Random messages, mostly short, some long.
    for (k = 0; k < NUM_RANDOM; k++) begin
      if (msg_left == 0)
        msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
      msg_left--;
      calm_stretch = (k >= 150 && k < 250);
      pick = $urandom_range(0, 9);
      b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      send_word(b, msg_left == 0 || k == NUM_RANDOM - 1, 32'h0);
    end
    in_valid <= 1'b0;
    calm_stretch = 1'b0;

    // Drain, then allow a few more cycles for stray words.
    while (chars_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && chars_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #400us;
    $display("Verification failed");
    $finish;
  end

endmodule
